// ===== design/sdu_pkg.sv =====
// Shared constants and types of the sorted distinct union block.
package sdu_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned WordWidth = 32;

  typedef logic signed [WordWidth-1:0] word_t;

  typedef struct packed {
    logic  valid;
    word_t value;
  } cell_t;

  typedef struct packed {
    logic  insert;
    logic  shift;
    word_t data;
  } cell_ctl_t;

endpackage

// ===== design/sdu_in_if.sv =====
// Input channel carrying one list element per word.
interface sdu_in_if
  import sdu_pkg::*;
();

  logic  valid;
  logic  ready;
  word_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

// ===== design/sdu_out_if.sv =====
// Output channel carrying one union value per word.
interface sdu_out_if
  import sdu_pkg::*;
();

  logic  valid;
  logic  ready;
  word_t value_res;
  logic  last_res;
  logic  overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input value_res, input last_res, input overflow,
                output ready);
endinterface

// ===== design/sdu_cell.sv =====
// One cell of the insertion chain: holds a single sorted value.
module sdu_cell
  import sdu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  cell_t     left_i,
  input  logic      left_lt_i,
  input  cell_t     right_i,
  output cell_t     cell_o,
  output logic      lt_o,
  output logic      eq_o
);

  cell_t cell_q;
  cell_t cell_d;

  assign lt_o = !cell_q.valid || (ctl_i.data < cell_q.value);
  assign eq_o = cell_q.valid && (ctl_i.data == cell_q.value);
  assign cell_o = cell_q;

  always_comb begin
    cell_d = cell_q;
    if (ctl_i.insert) begin
      if (left_lt_i) begin
        cell_d = left_i;
      end else if (lt_o) begin
        cell_d.valid = 1'b1;
        cell_d.value = ctl_i.data;
      end
    end else if (ctl_i.shift) begin
      cell_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

endmodule

// ===== design/sorted_distinct_union.sv =====
// Sorted distinct union: an insertion chain of cells that drains in ascending order.
//
// Input words (value, last) arrive on in_i; each is compared against every cell in
// the same cycle and inserted in place, so one word is accepted per cycle while the
// block collects. Duplicates are dropped. A new distinct value that finds all
// CAPACITY cells full is dropped and sets a sticky overflow flag.
// A word with last set is inserted like any other; from the next cycle the chain
// drains through out_o, smallest value first, one word per cycle while the receiver
// is ready. The result in cell 0 is the output register, so the first result is
// offered in the cycle after the last word is accepted; in_i is not ready during
// the drain. The final result carries last_res, and overflow is set on every
// result of a union that dropped a value.
// When the receiver stalls, the chain holds and the offered word stays stable.
// Reset empties all cells and clears the overflow flag; the block is ready at once.
module sorted_distinct_union
  import sdu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sdu_in_if.sink    in_i,
  sdu_out_if.source out_o
);

  cell_t                cells [CAPACITY];
  logic [CAPACITY-1:0]  lt_vec;
  logic [CAPACITY-1:0]  eq_vec;
  logic [CAPACITY-1:0]  valid_vec;
  cell_ctl_t            ctl;
  logic                 drain_q, drain_d;
  logic                 flag_q, flag_d;
  logic                 in_acc, out_acc, dup, full;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign dup     = |eq_vec;
  assign full    = valid_vec[CAPACITY-1];

  assign ctl.data   = in_i.value;
  assign ctl.insert = in_acc && !dup && !full;
  assign ctl.shift  = out_acc;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    cell_t left_cell;
    cell_t right_cell;
    logic  left_lt;

    if (i == 0) begin : g_first
      assign left_cell = '0;
      assign left_lt   = 1'b0;
    end else begin : g_mid
      assign left_cell = cells[i-1];
      assign left_lt   = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_cell = '0;
    end else begin : g_inner
      assign right_cell = cells[i+1];
    end

    sdu_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .left_i    (left_cell),
      .left_lt_i (left_lt),
      .right_i   (right_cell),
      .cell_o    (cells[i]),
      .lt_o      (lt_vec[i]),
      .eq_o      (eq_vec[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  assign in_i.ready      = !drain_q;
  assign out_o.valid     = drain_q && cells[0].valid;
  assign out_o.value_res = cells[0].value;
  assign out_o.overflow  = flag_q;
  if (CAPACITY > 1) begin : g_last_res
    assign out_o.last_res = !cells[1].valid;
  end else begin : g_last_res_single
    assign out_o.last_res = 1'b1;
  end

  always_comb begin
    drain_d = drain_q;
    flag_d  = flag_q;
    if (in_acc) begin
      if (full && !dup) begin
        flag_d = 1'b1;
      end
      if (in_i.last) begin
        drain_d = 1'b1;
      end
    end
    if (out_acc && out_o.last_res) begin
      drain_d = 1'b0;
      flag_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      drain_q <= drain_d;
      flag_q  <= flag_d;
    end
  end

  // The occupied cells always form an unbroken run starting at cell 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
    else $error("occupied cells are not contiguous");

  // Input is never taken while results are offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready during drain");

  // A last word is followed by a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last) |=> out_o.valid)
    else $error("no result after last word");

  // Results of one union rise strictly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_o.last_res) |=>
      (out_o.valid && (out_o.value_res > $past(out_o.value_res))))
    else $error("results not strictly ascending");

endmodule
